[rtl/lpcf_pkg.sv]
// lpcf_pkg: shared types, constants and the arctangent table of the lidar point crop filter
// no dependencies; used by every module under rtl/

package lpcf_pkg;

  localparam int NUM_SECTORS  = 4;
  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_STAGES = 16;

  localparam int CORDIC_MAX = 24;
  localparam int STG_W      = $clog2(CORDIC_MAX);
  // scaled by 256, one bit for the quadrant fold, two for cordic growth
  localparam int CORDIC_W   = COORD_WIDTH + 11;
  localparam int SQ_IN_W    = 2 * COORD_WIDTH;
  localparam int D2_W       = SQ_IN_W + 1;
  localparam int CFG_SQ_W   = 32;
  localparam int DC_W       = (D2_W > CFG_SQ_W) ? D2_W : CFG_SQ_W;
  localparam int HC_W       = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUND_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUND_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_BOX_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_BOX_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_PAIR_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_PAIR_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_ENABLE = 3'd7;

  localparam logic [31:0] RST_RANGE_LIMITS  = 32'h1400_001A;
  localparam logic [15:0] RST_GROUND_RADIUS = 16'h0A00;
  localparam logic [15:0] RST_GROUND_HEIGHT = 16'hFF80;
  localparam logic [31:0] RST_BODY_BOX      = 32'h0080_FF80;

  localparam logic [31:0] ANG_PLUS_QUARTER  = 32'h4000_0000;
  localparam logic [31:0] ANG_MINUS_QUARTER = 32'hC000_0000;
  localparam logic [31:0] ANG_ROUND         = 32'h0000_8000;

  typedef enum logic [2:0] {
    RSN_KEEP   = 3'd0,
    RSN_GROUND = 3'd1,
    RSN_RANGE  = 3'd2,
    RSN_SECTOR = 3'd3,
    RSN_BODY   = 3'd4
  } reason_t;

  typedef struct packed {
    logic [31:0]        range_limits;
    logic [15:0]        ground_radius;
    logic signed [15:0] ground_height;
    logic [31:0]        body_box_x;
    logic [31:0]        body_box_y;
    logic [63:0]        sector_pair_a;
    logic [63:0]        sector_pair_b;
    logic [3:0]         sector_enable;
  } cfg_t;

  // point word plus the early test results riding along the chain
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic [15:0]                   intensity;
    logic                          last;
    logic                          origin;
    logic                          body;
    reason_t                       pre_reason;
  } side_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic [31:0]                ang;
  } cordic_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_of(input logic [STG_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

[rtl/lpcf_front.sv]
// lpcf_front: two entry stages: squares and quadrant fold, then ground, range and body tests
// depends on lpcf_pkg; feeds the first cordic cell

module lpcf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  lpcf_pkg::cfg_t                      cfg,
  input  logic                                in_vld,
  input  logic signed [lpcf_pkg::COORD_WIDTH-1:0] in_x,
  input  logic signed [lpcf_pkg::COORD_WIDTH-1:0] in_y,
  input  logic signed [lpcf_pkg::COORD_WIDTH-1:0] in_z,
  input  logic [15:0]                         in_intensity,
  input  logic                                in_last,
  output logic                                out_vld,
  output lpcf_pkg::side_t                     out_side,
  output lpcf_pkg::cordic_t                   out_cs
);

  // config squares, registered from the config fields
  logic [lpcf_pkg::CFG_SQ_W-1:0] gr_sq_r, rmin_sq_r, rmax_sq_r;

  always_ff @(posedge clk) begin
    gr_sq_r   <= cfg.ground_radius * cfg.ground_radius;
    rmin_sq_r <= cfg.range_limits[15:0] * cfg.range_limits[15:0];
    rmax_sq_r <= cfg.range_limits[31:16] * cfg.range_limits[31:16];
  end

  // stage 0
  logic                                   s0_vld_r;
  logic signed [lpcf_pkg::COORD_WIDTH-1:0] s0_x_r, s0_y_r, s0_z_r;
  logic [15:0]                            s0_int_r;
  logic                                   s0_last_r, s0_origin_r;
  logic [lpcf_pkg::SQ_IN_W-1:0]           s0_xx_r, s0_yy_r, xx_nxt, yy_nxt;
  lpcf_pkg::cordic_t                      s0_cs_r, cs_nxt;
  logic signed [lpcf_pkg::CORDIC_W-1:0]   xe, ye;

  assign xx_nxt = in_x * in_x;
  assign yy_nxt = in_y * in_y;
  assign xe     = lpcf_pkg::CORDIC_W'(in_x);
  assign ye     = lpcf_pkg::CORDIC_W'(in_y);

  // fold the left half plane by a quarter turn, then scale by 256
  always_comb begin
    if (in_x < 0) begin
      if (in_y >= 0) begin
        cs_nxt.cx  = ye <<< 8;
        cs_nxt.cy  = (-xe) <<< 8;
        cs_nxt.ang = lpcf_pkg::ANG_PLUS_QUARTER;
      end else begin
        cs_nxt.cx  = (-ye) <<< 8;
        cs_nxt.cy  = xe <<< 8;
        cs_nxt.ang = lpcf_pkg::ANG_MINUS_QUARTER;
      end
    end else begin
      cs_nxt.cx  = xe <<< 8;
      cs_nxt.cy  = ye <<< 8;
      cs_nxt.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_x_r      <= in_x;
      s0_y_r      <= in_y;
      s0_z_r      <= in_z;
      s0_int_r    <= in_intensity;
      s0_last_r   <= in_last;
      s0_origin_r <= (in_x == '0) && (in_y == '0);
      s0_xx_r     <= xx_nxt;
      s0_yy_r     <= yy_nxt;
      s0_cs_r     <= cs_nxt;
    end
  end

  // stage 1
  logic [lpcf_pkg::D2_W-1:0]            d2;
  logic [lpcf_pkg::DC_W-1:0]            d2_e, gr_e, rmin_e, rmax_e;
  logic signed [lpcf_pkg::HC_W-1:0]     z_e, y_e, x_e, gh_e, bxlo, bxhi, bylo, byhi;
  logic                                 ground, range_out, body_nxt;
  lpcf_pkg::reason_t                    pre_nxt;
  logic                                 s1_vld_r;
  lpcf_pkg::side_t                      s1_side_r;
  lpcf_pkg::cordic_t                    s1_cs_r;

  assign d2     = {1'b0, s0_xx_r} + {1'b0, s0_yy_r};
  assign d2_e   = lpcf_pkg::DC_W'(d2);
  assign gr_e   = lpcf_pkg::DC_W'(gr_sq_r);
  assign rmin_e = lpcf_pkg::DC_W'(rmin_sq_r);
  assign rmax_e = lpcf_pkg::DC_W'(rmax_sq_r);

  assign x_e  = lpcf_pkg::HC_W'(s0_x_r);
  assign y_e  = lpcf_pkg::HC_W'(s0_y_r);
  assign z_e  = lpcf_pkg::HC_W'(s0_z_r);
  assign gh_e = lpcf_pkg::HC_W'(cfg.ground_height);
  assign bxlo = lpcf_pkg::HC_W'($signed(cfg.body_box_x[15:0]));
  assign bxhi = lpcf_pkg::HC_W'($signed(cfg.body_box_x[31:16]));
  assign bylo = lpcf_pkg::HC_W'($signed(cfg.body_box_y[15:0]));
  assign byhi = lpcf_pkg::HC_W'($signed(cfg.body_box_y[31:16]));

  assign ground    = (d2_e > gr_e) && (z_e < gh_e);
  assign range_out = (d2_e < rmin_e) || (d2_e > rmax_e);
  assign body_nxt  = (x_e >= bxlo) && (x_e <= bxhi) && (y_e >= bylo) && (y_e <= byhi);

  always_comb begin
    if (ground) begin
      pre_nxt = lpcf_pkg::RSN_GROUND;
    end else if (range_out) begin
      pre_nxt = lpcf_pkg::RSN_RANGE;
    end else begin
      pre_nxt = lpcf_pkg::RSN_KEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= s0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r.x          <= s0_x_r;
      s1_side_r.y          <= s0_y_r;
      s1_side_r.z          <= s0_z_r;
      s1_side_r.intensity  <= s0_int_r;
      s1_side_r.last       <= s0_last_r;
      s1_side_r.origin     <= s0_origin_r;
      s1_side_r.body       <= body_nxt;
      s1_side_r.pre_reason <= pre_nxt;
      s1_cs_r              <= s0_cs_r;
    end
  end

  assign out_vld  = s1_vld_r;
  assign out_side = s1_side_r;
  assign out_cs   = s1_cs_r;

endmodule

[rtl/lpcf_cordic_cell.sv]
// lpcf_cordic_cell: one vectoring cordic step with its own register, carrying the point along
// depends on lpcf_pkg; instanced once per step by the top level

module lpcf_cordic_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [lpcf_pkg::STG_W-1:0]  stage,
  input  logic                        in_vld,
  input  lpcf_pkg::side_t             in_side,
  input  lpcf_pkg::cordic_t           in_cs,
  output logic                        out_vld,
  output lpcf_pkg::side_t             out_side,
  output lpcf_pkg::cordic_t           out_cs
);

  logic signed [lpcf_pkg::CORDIC_W-1:0] cx, cy, dx, dy;
  logic [31:0]                          step_ang;
  lpcf_pkg::cordic_t                    cs_nxt;
  logic                                 vld_r;
  lpcf_pkg::side_t                      side_r;
  lpcf_pkg::cordic_t                    cs_r;

  assign cx       = in_cs.cx;
  assign cy       = in_cs.cy;
  assign dx       = cy >>> stage;
  assign dy       = cx >>> stage;
  assign step_ang = lpcf_pkg::atan_of(stage);

  // y of zero counts as positive
  always_comb begin
    if (!cy[lpcf_pkg::CORDIC_W-1]) begin
      cs_nxt.cx  = cx + dx;
      cs_nxt.cy  = cy - dy;
      cs_nxt.ang = in_cs.ang + step_ang;
    end else begin
      cs_nxt.cx  = cx - dx;
      cs_nxt.cy  = cy + dy;
      cs_nxt.ang = in_cs.ang - step_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r <= in_side;
      cs_r   <= cs_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_cs   = cs_r;

endmodule

[rtl/lpcf_classify.sv]
// lpcf_classify: bearing rounding, blocked sector match and the final drop reason, output register
// depends on lpcf_pkg; takes the last cordic cell

module lpcf_classify (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  lpcf_pkg::cfg_t                       cfg,
  input  logic                                 in_vld,
  input  lpcf_pkg::side_t                      in_side,
  input  lpcf_pkg::cordic_t                    in_cs,
  output logic                                 out_vld,
  output logic signed [lpcf_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [lpcf_pkg::COORD_WIDTH-1:0] out_y,
  output logic signed [lpcf_pkg::COORD_WIDTH-1:0] out_z,
  output logic [15:0]                          out_intensity,
  output logic                                 out_keep,
  output lpcf_pkg::reason_t                    out_reason,
  output logic                                 out_last
);

  logic [31:0]        ang_rnd;
  logic signed [15:0] bear;
  logic [127:0]       sec_all;
  logic               sec_hit;
  lpcf_pkg::reason_t  reason_nxt;

  logic               vld_r;
  lpcf_pkg::side_t    side_r;
  lpcf_pkg::reason_t  reason_r;

  assign ang_rnd = in_cs.ang + lpcf_pkg::ANG_ROUND;
  assign bear    = in_side.origin ? 16'sd0 : $signed(ang_rnd[31:16]);
  assign sec_all = {cfg.sector_pair_b, cfg.sector_pair_a};

  always_comb begin
    sec_hit = 1'b0;
    for (int s = 0; s < lpcf_pkg::NUM_SECTORS; s++) begin
      if (cfg.sector_enable[s] &&
          bear >= $signed(sec_all[32*s +: 16]) &&
          bear <= $signed(sec_all[32*s+16 +: 16])) begin
        sec_hit = 1'b1;
      end
    end
  end

  always_comb begin
    if (in_side.pre_reason != lpcf_pkg::RSN_KEEP) begin
      reason_nxt = in_side.pre_reason;
    end else if (sec_hit) begin
      reason_nxt = lpcf_pkg::RSN_SECTOR;
    end else if (in_side.body) begin
      reason_nxt = lpcf_pkg::RSN_BODY;
    end else begin
      reason_nxt = lpcf_pkg::RSN_KEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r   <= in_side;
      reason_r <= reason_nxt;
    end
  end

  assign out_vld       = vld_r;
  assign out_x         = side_r.x;
  assign out_y         = side_r.y;
  assign out_z         = side_r.z;
  assign out_intensity = side_r.intensity;
  assign out_reason    = reason_r;
  assign out_keep      = (reason_r == lpcf_pkg::RSN_KEEP);
  assign out_last      = side_r.last;

endmodule

[rtl/lidar_point_crop_filter_top.sv]
// lidar_point_crop_filter_top: config registers, entry stages, cordic cell chain, classifier
// depends on lpcf_pkg, lpcf_front, lpcf_cordic_cell, lpcf_classify
//
//   channel  direction  handshake              word
//   in_      in         in_valid / in_stall    x, y, z, intensity, end-of-cloud mark
//   out_     out        out_valid / out_stall  point copy, keep, drop reason, scan end
//   cfg_     in         cfg_valid / cfg_ready  register index, 64-bit write data
//
// one point per cycle while the output is not stalled; two entry stages,
// one cordic cell per bearing step, one classify and output stage
// the cordic cell chain sets the latency; each cell holds one point
// reset clears all valid bits and loads the register reset values, no clearing pass
// a stalled output word freezes the whole chain, and in_stall follows it
// config writes are taken every cycle

module lidar_point_crop_filter_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lpcf_pkg::COORD_WIDTH-1:0] in_x_pos,
  input  logic signed [lpcf_pkg::COORD_WIDTH-1:0] in_y_pos,
  input  logic signed [lpcf_pkg::COORD_WIDTH-1:0] in_z_pos,
  input  logic [15:0]                         in_intensity,
  input  logic                                in_last_of_cloud,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lpcf_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [lpcf_pkg::COORD_WIDTH-1:0] out_y,
  output logic signed [lpcf_pkg::COORD_WIDTH-1:0] out_z,
  output logic [15:0]                         out_intensity,
  output logic                                out_keep,
  output logic [2:0]                          out_drop_reason,
  output logic                                out_scan_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lpcf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lpcf_pkg::cfg_t cfg_r;
  logic           adv;

  assign cfg_ready = 1'b1;
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.range_limits  <= lpcf_pkg::RST_RANGE_LIMITS;
      cfg_r.ground_radius <= lpcf_pkg::RST_GROUND_RADIUS;
      cfg_r.ground_height <= lpcf_pkg::RST_GROUND_HEIGHT;
      cfg_r.body_box_x    <= lpcf_pkg::RST_BODY_BOX;
      cfg_r.body_box_y    <= lpcf_pkg::RST_BODY_BOX;
      cfg_r.sector_pair_a <= '0;
      cfg_r.sector_pair_b <= '0;
      cfg_r.sector_enable <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpcf_pkg::CFG_RANGE_LIMITS:  cfg_r.range_limits  <= cfg_data[31:0];
        lpcf_pkg::CFG_GROUND_RADIUS: cfg_r.ground_radius <= cfg_data[15:0];
        lpcf_pkg::CFG_GROUND_HEIGHT: cfg_r.ground_height <= cfg_data[15:0];
        lpcf_pkg::CFG_BODY_BOX_X:    cfg_r.body_box_x    <= cfg_data[31:0];
        lpcf_pkg::CFG_BODY_BOX_Y:    cfg_r.body_box_y    <= cfg_data[31:0];
        lpcf_pkg::CFG_SECTOR_PAIR_A: cfg_r.sector_pair_a <= cfg_data;
        lpcf_pkg::CFG_SECTOR_PAIR_B: cfg_r.sector_pair_b <= cfg_data;
        lpcf_pkg::CFG_SECTOR_ENABLE: cfg_r.sector_enable <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic              vld_w  [lpcf_pkg::ANGLE_STAGES+1];
  lpcf_pkg::side_t   side_w [lpcf_pkg::ANGLE_STAGES+1];
  lpcf_pkg::cordic_t cs_w   [lpcf_pkg::ANGLE_STAGES+1];

  lpcf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .cfg          (cfg_r),
    .in_vld       (in_valid),
    .in_x         (in_x_pos),
    .in_y         (in_y_pos),
    .in_z         (in_z_pos),
    .in_intensity (in_intensity),
    .in_last      (in_last_of_cloud),
    .out_vld      (vld_w[0]),
    .out_side     (side_w[0]),
    .out_cs       (cs_w[0])
  );

  for (genvar g = 0; g < lpcf_pkg::ANGLE_STAGES; g++) begin : g_cell
    lpcf_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .stage    (lpcf_pkg::STG_W'(g)),
      .in_vld   (vld_w[g]),
      .in_side  (side_w[g]),
      .in_cs    (cs_w[g]),
      .out_vld  (vld_w[g+1]),
      .out_side (side_w[g+1]),
      .out_cs   (cs_w[g+1])
    );
  end

  lpcf_pkg::reason_t reason;

  lpcf_classify u_classify (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .cfg           (cfg_r),
    .in_vld        (vld_w[lpcf_pkg::ANGLE_STAGES]),
    .in_side       (side_w[lpcf_pkg::ANGLE_STAGES]),
    .in_cs         (cs_w[lpcf_pkg::ANGLE_STAGES]),
    .out_vld       (out_valid),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_intensity (out_intensity),
    .out_keep      (out_keep),
    .out_reason    (reason),
    .out_last      (out_scan_end)
  );

  assign out_drop_reason = reason;

  // keep flag agrees with the reason code
  a_keep_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_keep == (out_drop_reason == lpcf_pkg::RSN_KEEP)))
    else $error("keep flag disagrees with drop reason");

  // only defined reason codes leave the block
  a_reason_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_drop_reason == lpcf_pkg::RSN_KEEP ||
                   out_drop_reason == lpcf_pkg::RSN_GROUND ||
                   out_drop_reason == lpcf_pkg::RSN_RANGE ||
                   out_drop_reason == lpcf_pkg::RSN_SECTOR ||
                   out_drop_reason == lpcf_pkg::RSN_BODY))
    else $error("undefined drop reason");

  // an accepted word passes both entry stage registers to the first cordic cell input unless the chain freezes
  a_entry_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !in_stall |=> vld_w[0])
    else $error("accepted word lost in the entry stages");

  // a frozen chain keeps the first cell's word
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(vld_w[0]) && $stable(side_w[0])))
    else $error("entry stage moved while the chain was frozen");

endmodule
